// ===== src/csdm_pkg.sv =====
// shared types and constants for the coo sparse times dense multiply block
// used by csdm_mac and coo_sparse_dense_multiply; depends on nothing else
package csdm_pkg;

    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 8;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int COLS_W    = IDX_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * VALUE_W;

    localparam logic [COLS_W-1:0] MAX_COLS = COLS_W'(1 << IDX_W);

    // request kinds carried on s_tuser
    localparam logic [1:0] MODE_LOAD_DENSE = 2'd0;
    localparam logic [1:0] MODE_LOAD_ACCUM = 2'd1;
    localparam logic [1:0] MODE_APPLY      = 2'd2;
    localparam logic [1:0] MODE_READ       = 2'd3;

    // configuration register byte offsets
    localparam logic [2:0] REG_ACTIVE_COLUMNS = 3'd0;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } mac_ctl_t;

endpackage

// ===== src/csdm_mac.sv =====
// shared multiply-accumulate unit: q16.16 product, floor shift, saturating add
// depends on csdm_pkg
module csdm_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  csdm_pkg::mac_ctl_t in_ctl,
    input  csdm_pkg::value_t  coef,
    input  csdm_pkg::value_t  dense,
    input  csdm_pkg::value_t  acc,
    output csdm_pkg::mac_ctl_t out_ctl,
    output csdm_pkg::value_t  sum
);

    localparam int VW = csdm_pkg::VALUE_W;
    localparam int PW = csdm_pkg::PROD_W;
    localparam int FB = csdm_pkg::FRAC_BITS;

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    logic signed [PW-1:0] prod_reg;
    csdm_pkg::value_t     acc_reg;
    csdm_pkg::mac_ctl_t   ctl_reg;

    logic                 prod_fits;
    csdm_pkg::value_t     prod_sat;
    logic signed [VW:0]   sum_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= coef * dense;
        acc_reg  <= acc;
    end

    // dropping the low fraction bits of a two's complement product floors it
    always_comb begin
        prod_fits = (prod_reg[PW-1:FB+VW-1] == {(PW-FB-VW+1){1'b0}})
                 || (prod_reg[PW-1:FB+VW-1] == {(PW-FB-VW+1){1'b1}});
        if (prod_fits) begin
            prod_sat = prod_reg[FB+VW-1:FB];
        end else if (prod_reg[PW-1]) begin
            prod_sat = VAL_MIN;
        end else begin
            prod_sat = VAL_MAX;
        end
        sum_wide = {acc_reg[VW-1], acc_reg} + {prod_sat[VW-1], prod_sat};
        if (sum_wide[VW] == sum_wide[VW-1]) begin
            sum = sum_wide[VW-1:0];
        end else if (sum_wide[VW]) begin
            sum = VAL_MIN;
        end else begin
            sum = VAL_MAX;
        end
    end

    assign out_ctl = ctl_reg;

endmodule

// ===== src/coo_sparse_dense_multiply.sv =====
// top level of the coo sparse times dense multiply block
// holds the dense and accumulator stores and the sequencer; uses csdm_pkg and csdm_mac
//
// usage
// - input channel s_*: one request per handshake; s_tuser selects the kind
//   (load dense element, load accumulator element, apply nonzero, read accumulator)
//   and s_tdata carries row, col and a signed q16.16 value
// - output channel m_*: one q16.16 accumulator element for each read request
// - apb port: register 0 at byte offset 0 is active_columns (9 bits, reset 256,
//   values above 256 act as 256, zero walks no columns)
// timing
// - loads write the store at the accepting edge
// - an apply walks the active columns through one shared multiply-accumulate
//   unit, one column per cycle; memory read, multiply and saturating
//   write-back are three register stages
// - a read result is read from the store into a register, then moved into the output register
// - s_tready is high only while the sequencer is idle
// reset clears the sequencer and the output valid and sets active_columns to 256;
// the stores are not cleared, every entry has to be loaded before it is used
// a stalled receiver holds the result in the output register; loads and
// applies still go on, and a further read waits until the register frees up
module coo_sparse_dense_multiply (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // row [7:0], col [15:8], value [47:16]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value [31:0]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = csdm_pkg::IDX_W;
    localparam int AW = csdm_pkg::ADDR_W;
    localparam int CW = csdm_pkg::COLS_W;
    localparam int VW = csdm_pkg::VALUE_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_APPLY  = 2'd1;
    localparam logic [1:0] ST_RD_MEM = 2'd2;
    localparam logic [1:0] ST_RD_OUT = 2'd3;

    // request fields
    logic [IW-1:0]    in_row;
    logic [IW-1:0]    in_col;
    csdm_pkg::value_t in_value;
    logic [1:0]       in_mode;
    logic             in_accept;

    assign in_row   = s_tdata[IW-1:0];
    assign in_col   = s_tdata[2*IW-1:IW];
    assign in_value = s_tdata[2*IW+VW-1:2*IW];
    assign in_mode  = s_tuser;

    logic [1:0]       state_reg, state_next;
    logic [IW-1:0]    row_reg;
    logic [IW-1:0]    col_reg;
    csdm_pkg::value_t val_reg;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    ncols_reg;
    logic [CW-1:0]    active_cols_reg;

    logic             m_valid_reg;
    logic [VW-1:0]    m_data_reg;

    // stores, contents undefined until loaded
    csdm_pkg::value_t dense_mem [1 << AW];
    csdm_pkg::value_t accum_mem [1 << AW];
    csdm_pkg::value_t dense_q_reg;
    csdm_pkg::value_t acc_q_reg;

    logic [AW-1:0]    dense_raddr;
    logic [AW-1:0]    acc_raddr;
    logic [AW-1:0]    acc_waddr;
    csdm_pkg::value_t acc_wdata;
    logic             acc_we;
    logic             dense_we;

    logic               issue;
    csdm_pkg::mac_ctl_t p1_reg;
    csdm_pkg::mac_ctl_t mac_out;
    csdm_pkg::value_t   mac_sum;
    logic               out_load;
    logic               cfg_write;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // one column issued per cycle while the walk is not done
    assign issue = (state_reg == ST_APPLY) && (cnt_reg < ncols_reg);

    assign dense_raddr = {col_reg, cnt_reg[IW-1:0]};
    assign acc_raddr   = (state_reg == ST_APPLY) ? {row_reg, cnt_reg[IW-1:0]}
                                                 : {row_reg, col_reg};

    // load requests write at the accepting edge; the mac writes back otherwise
    assign dense_we = in_accept && (in_mode == csdm_pkg::MODE_LOAD_DENSE);

    always_comb begin
        if (mac_out.valid) begin
            acc_we    = 1'b1;
            acc_waddr = {row_reg, mac_out.idx};
            acc_wdata = mac_sum;
        end else begin
            acc_we    = in_accept && (in_mode == csdm_pkg::MODE_LOAD_ACCUM);
            acc_waddr = {in_row, in_col};
            acc_wdata = in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (dense_we) begin
            dense_mem[{in_row, in_col}] <= in_value;
        end
        dense_q_reg <= dense_mem[dense_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            accum_mem[acc_waddr] <= acc_wdata;
        end
        acc_q_reg <= accum_mem[acc_raddr];
    end

    // read data stage ahead of the mac
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg <= '0;
        end else begin
            p1_reg.valid <= issue;
            p1_reg.idx   <= cnt_reg[IW-1:0];
        end
    end

    csdm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_ctl  (p1_reg),
        .coef    (val_reg),
        .dense   (dense_q_reg),
        .acc     (acc_q_reg),
        .out_ctl (mac_out),
        .sum     (mac_sum)
    );

    // sequencer
    assign out_load = (state_reg == ST_RD_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_mode)
                        csdm_pkg::MODE_APPLY: state_next = ST_APPLY;
                        csdm_pkg::MODE_READ:  state_next = ST_RD_MEM;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_APPLY: begin
                // done once all columns are issued and the pipe has drained
                if (!issue && !p1_reg.valid && !mac_out.valid) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_MEM: begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (in_accept) begin
                cnt_reg <= '0;
            end else if (issue) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // request payload and the clamped column count
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            row_reg   <= in_row;
            col_reg   <= in_col;
            val_reg   <= in_value;
            ncols_reg <= (active_cols_reg > csdm_pkg::MAX_COLS) ? csdm_pkg::MAX_COLS
                                                                : active_cols_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= acc_q_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // apb register file, low address bits ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_cols_reg <= csdm_pkg::MAX_COLS;
        end else if (cfg_write && (paddr[2] == csdm_pkg::REG_ACTIVE_COLUMNS[2])) begin
            active_cols_reg <= pwdata[CW-1:0];
        end
    end

    assign prdata = (paddr[2] == csdm_pkg::REG_ACTIVE_COLUMNS[2])
                  ? {{(32-CW){1'b0}}, active_cols_reg} : 32'd0;

    // checks
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while sequencer busy");

    a_writeback_in_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_out.valid |-> (state_reg == ST_APPLY))
        else $error("mac write-back outside an apply walk");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> (cnt_reg <= ncols_reg))
        else $error("column counter ran past the column count");

    a_issue_to_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> ##1 mac_out.valid)
        else $error("issued column lost in the pipe");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for coo_sparse_dense_multiply: element loads, sparse applies and
// accumulator reads, checked against a q16.16 multiply-accumulate mirror kept in the bench
// depends on csdm_pkg and the coo_sparse_dense_multiply rtl
module testbench;

    localparam int     SETTLE_CYCLES = 300;     // covers the longest apply, which walks 256 columns
    localparam int     DRAIN_LIMIT   = 200000;  // cycles allowed for outstanding reads
    localparam int     RANDOM_ITEMS  = 1750;
    localparam int     PHASES        = 9;
    localparam int     SCRIPT_LEN    = 23;
    localparam int     PRINT_LIMIT   = 40;
    localparam longint Q_HI          = 64'sd2147483647;
    localparam longint Q_LO          = -64'sd2147483648;

    // one directed request; result is only meaningful where typed is set
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [31:0] value;
        logic        typed;
        logic [31:0] result;
    } script_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // row [7:0], col [15:8], value [47:16]
    logic [1:0]  s_tuser  = csdm_pkg::MODE_LOAD_DENSE;   // mode [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // read_value [31:0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = csdm_pkg::REG_ACTIVE_COLUMNS;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // mirror of the two stores, plus which entries have been loaded so far
    csdm_pkg::value_t dense_mirror [65536];
    csdm_pkg::value_t accum_mirror [65536];
    bit          dense_loaded [65536];
    bit          accum_loaded [65536];
    int unsigned accum_loaded_list [$];
    logic [8:0]  columns_setting = 9'd256;

    logic [31:0] expected_reads [$];   // accumulator values still owed on m_*
    int          error_count   = 0;
    int          requests_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [7:0]  hot_rows [4];         // favored indices so applies reuse loaded rows

    coo_sparse_dense_multiply dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic flag_error(string msg);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic csdm_pkg::value_t clamp_q(longint v);
        if (v > Q_HI) return csdm_pkg::value_t'(Q_HI);
        if (v < Q_LO) return csdm_pkg::value_t'(Q_LO);
        return csdm_pkg::value_t'(v);
    endfunction

    // full q16.16 product, arithmetic shift floors toward minus infinity
    function automatic csdm_pkg::value_t q16_product(csdm_pkg::value_t a,
                                                     csdm_pkg::value_t b);
        longint full;
        full = longint'(a) * longint'(b);
        return clamp_q(full >>> csdm_pkg::FRAC_BITS);
    endfunction

    // settings above 256 walk all 256 columns, zero walks none
    function automatic int walked_columns();
        return (columns_setting > csdm_pkg::MAX_COLS) ? int'(csdm_pkg::MAX_COLS)
                                                      : int'(columns_setting);
    endfunction

    function automatic void apply_to_mirror(logic [7:0] row, logic [7:0] col,
                                            csdm_pkg::value_t v);
        int          n;
        logic [15:0] acc_at;
        n = walked_columns();
        for (int i = 0; i < n; i++) begin
            acc_at = {row, 8'(i)};
            accum_mirror[acc_at] = clamp_q(longint'(accum_mirror[acc_at])
                + longint'(q16_product(v, dense_mirror[{col, 8'(i)}])));
        end
    endfunction

    // updates the mirror for one accepted request; returns 1 when a read value is owed
    function automatic bit predict_request(logic [1:0] mode, logic [7:0] row,
                                           logic [7:0] col, csdm_pkg::value_t v,
                                           output logic [31:0] read_value);
        logic [15:0] at;
        at = {row, col};
        read_value = '0;
        case (mode)
            csdm_pkg::MODE_LOAD_DENSE: begin
                dense_mirror[at] = v;
                dense_loaded[at] = 1'b1;
            end
            csdm_pkg::MODE_LOAD_ACCUM: begin
                if (!accum_loaded[at]) accum_loaded_list.push_back(32'(at));
                accum_mirror[at] = v;
                accum_loaded[at] = 1'b1;
            end
            csdm_pkg::MODE_APPLY: apply_to_mirror(row, col, v);
            csdm_pkg::MODE_READ: begin
                read_value = accum_mirror[at];
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // mostly moderate magnitudes so sums do not pin at the rails, with extremes mixed in
    function automatic csdm_pkg::value_t pick_value();
        case ($urandom_range(7))
            0, 1: return csdm_pkg::value_t'($urandom);
            2: begin
                case ($urandom_range(4))
                    0:       return csdm_pkg::value_t'(Q_HI);
                    1:       return csdm_pkg::value_t'(Q_LO);
                    2:       return '0;
                    3:       return '1;
                    default: return 32'h0001_0000;
                endcase
            end
            default: return csdm_pkg::value_t'($signed($urandom) >>> $urandom_range(20, 4));
        endcase
    endfunction

    // drives one request, with random leading gaps, and waits for the handshake;
    // valid is left high so back-to-back requests never drop it in between
    task automatic send_request(logic [1:0] mode, logic [7:0] row, logic [7:0] col,
                                csdm_pkg::value_t v, bit typed, logic [31:0] typed_value);
        logic [31:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {v, col, row};
        do @(posedge aclk); while (s_tready !== 1'b1);
        requests_sent++;
        if (predict_request(mode, row, col, v, predicted))
            expected_reads.push_back(typed ? typed_value : predicted);
    endtask

    task automatic read_loaded_entry();
        int unsigned at;
        at = accum_loaded_list[$urandom_range(accum_loaded_list.size() - 1)];
        send_request(csdm_pkg::MODE_READ, at[15:8], at[7:0], pick_value(), 1'b0, '0);
    endtask

    // well-formed apply: load whatever the walk will touch, apply, then read back a few
    task automatic apply_sequence(logic [7:0] row, logic [7:0] col, csdm_pkg::value_t v);
        int         n;
        logic [7:0] c;
        n = walked_columns();
        for (int i = 0; i < n; i++) begin
            if (!dense_loaded[{col, 8'(i)}])
                send_request(csdm_pkg::MODE_LOAD_DENSE, col, 8'(i), pick_value(), 1'b0, '0);
            if (!accum_loaded[{row, 8'(i)}])
                send_request(csdm_pkg::MODE_LOAD_ACCUM, row, 8'(i), pick_value(), 1'b0, '0);
        end
        send_request(csdm_pkg::MODE_APPLY, row, col, v, 1'b0, '0);
        if (n > 0) begin
            repeat ($urandom_range(3)) begin
                c = 8'($urandom_range(n - 1));
                send_request(csdm_pkg::MODE_READ, row, c, pick_value(), 1'b0, '0);
            end
        end
    endtask

    // holds requests off until every read has come back and an apply could have finished
    task automatic settle_block();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_reads.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_reads.size() != 0) begin
            flag_error($sformatf("%0d read values never arrived", expected_reads.size()));
            expected_reads.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_active_columns(logic [8:0] setting);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= csdm_pkg::REG_ACTIVE_COLUMNS;
        pwdata  <= 32'(setting);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        columns_setting = setting;
    endtask

    task automatic run_phase(int target);
        logic [7:0] row;
        logic [7:0] col;
        while (requests_sent < target) begin
            row = ($urandom_range(3) != 0) ? hot_rows[$urandom_range(3)] : 8'($urandom);
            col = ($urandom_range(3) != 0) ? hot_rows[$urandom_range(3)] : 8'($urandom);
            case ($urandom_range(9))
                0, 1:    send_request(csdm_pkg::MODE_LOAD_DENSE, 8'($urandom), 8'($urandom),
                                      pick_value(), 1'b0, '0);
                2, 3:    send_request(csdm_pkg::MODE_LOAD_ACCUM, 8'($urandom), 8'($urandom),
                                      pick_value(), 1'b0, '0);
                4, 5, 6: apply_sequence(row, col, pick_value());
                default: read_loaded_entry();
            endcase
        end
    endtask

    // ---------------------------------------------------------------- result side

    // random backpressure; every accepted result is matched against the oldest read owed
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_reads.size() == 0) begin
                flag_error($sformatf("read value %h with no read request pending", m_tdata));
            end else begin
                want = expected_reads.pop_front();
                if (m_tdata !== want)
                    flag_error($sformatf("read_value got %h want %h", m_tdata, want));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------- run

    initial begin
        script_row_t script [SCRIPT_LEN];
        logic [8:0]  settings [PHASES];

        // directed walk with two active columns: rails, saturation both ways,
        // floor rounding of negative products, lowest and highest indices
        script = '{
            {csdm_pkg::MODE_LOAD_DENSE, 8'd0,   8'd0,   32'h0001_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_LOAD_DENSE, 8'd0,   8'd1,   32'h0002_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_LOAD_ACCUM, 8'd5,   8'd0,   32'h0003_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_LOAD_ACCUM, 8'd5,   8'd1,   32'h7fff_ffff, 1'b0, 32'h0},
            {csdm_pkg::MODE_READ,       8'd5,   8'd0,   32'h0,         1'b1, 32'h0003_0000},
            {csdm_pkg::MODE_READ,       8'd5,   8'd1,   32'h0,         1'b1, 32'h7fff_ffff},
            {csdm_pkg::MODE_APPLY,      8'd5,   8'd0,   32'h0001_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_READ,       8'd5,   8'd0,   32'h0,         1'b1, 32'h0004_0000},
            {csdm_pkg::MODE_READ,       8'd5,   8'd1,   32'h0,         1'b1, 32'h7fff_ffff},
            {csdm_pkg::MODE_LOAD_DENSE, 8'd255, 8'd0,   32'h8000_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_LOAD_DENSE, 8'd255, 8'd1,   32'h7fff_ffff, 1'b0, 32'h0},
            {csdm_pkg::MODE_LOAD_ACCUM, 8'd255, 8'd0,   32'h8000_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_LOAD_ACCUM, 8'd255, 8'd1,   32'h0000_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_APPLY,      8'd255, 8'd255, 32'h8000_0000, 1'b0, 32'h0},
            {csdm_pkg::MODE_READ,       8'd255, 8'd0,   32'h0,         1'b1, 32'hffff_ffff},
            {csdm_pkg::MODE_READ,       8'd255, 8'd1,   32'h0,         1'b1, 32'h8000_0000},
            {csdm_pkg::MODE_APPLY,      8'd255, 8'd255, 32'hffff_ffff, 1'b0, 32'h0},
            {csdm_pkg::MODE_READ,       8'd255, 8'd0,   32'h0,         1'b1, 32'h0000_7fff},
            {csdm_pkg::MODE_READ,       8'd255, 8'd1,   32'h0,         1'b1, 32'h8000_0000},
            {csdm_pkg::MODE_LOAD_DENSE, 8'd0,   8'd0,   32'h0000_0001, 1'b0, 32'h0},
            {csdm_pkg::MODE_APPLY,      8'd5,   8'd0,   32'hffff_ffff, 1'b0, 32'h0},
            {csdm_pkg::MODE_READ,       8'd5,   8'd0,   32'h0,         1'b1, 32'h0003_ffff},
            {csdm_pkg::MODE_READ,       8'd5,   8'd1,   32'h0,         1'b1, 32'h7fff_fffd}
        };
        // column counts per random phase: zero, one, exactly 256 and the top code
        settings = '{9'd4, 9'd1, 9'd0, 9'd256, 9'd13, 9'd511, 9'd2, 9'd64, 9'd7};
        foreach (hot_rows[k]) hot_rows[k] = 8'($urandom);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        write_active_columns(9'd2);
        foreach (script[k])
            send_request(script[k].mode, script[k].row, script[k].col, script[k].value,
                         script[k].typed, script[k].result);
        settle_block();

        // thirds: sender light and receiver heavy, then swapped, then no idling
        for (int p = 0; p < PHASES; p++) begin
            case (p / 3)
                0: begin send_idle_pct = 20; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_active_columns(settings[p]);
            // cumulative target keeps the total near the planned count
            run_phase(SCRIPT_LEN + RANDOM_ITEMS * (p + 1) / PHASES);
            settle_block();
        end

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #(30_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
